FILE: rtl/gpl_pkg.sv
`timescale 1ns / 1ps
package gpl_pkg;

  localparam int PIN_COUNT = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int NIB_W     = 4;
  localparam int HALF_PINS = PIN_COUNT / 2;
  localparam int KEY_POS   = 16;

  localparam logic [DATA_W-1:0] CFG_RESET = 32'h4444_4444;

  localparam logic [IDX_W-1:0] REG_CFG_LO = 3'd0;
  localparam logic [IDX_W-1:0] REG_CFG_HI = 3'd1;
  localparam logic [IDX_W-1:0] REG_INPUT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUTPUT = 3'd3;
  localparam logic [IDX_W-1:0] REG_SET    = 3'd4;
  localparam logic [IDX_W-1:0] REG_RESET  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LOCK   = 3'd6;
  localparam logic [IDX_W-1:0] REG_NONE   = 3'd7;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              fire;
    logic              wr;
    logic              sel;
    logic [DATA_W-1:0] data;
  } gpl_lock_req_t;

  typedef struct packed {
    logic [PIN_COUNT-1:0] mask;
    logic                 key;
    logic                 key_next;
  } gpl_lock_st_t;

endpackage

FILE: rtl/gpl_if.sv
`timescale 1ns / 1ps
interface gpl_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [gpl_pkg::IDX_W-1:0]      reg_index;
  logic [gpl_pkg::DATA_W-1:0]     write_data;
  logic [gpl_pkg::PIN_COUNT-1:0]  pin_levels;

  modport source (output valid, opcode, reg_index, write_data, pin_levels, input ready);
  modport sink   (input valid, opcode, reg_index, write_data, pin_levels, output ready);
endinterface

interface gpl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [gpl_pkg::DATA_W-1:0]     read_data;
  logic [gpl_pkg::PIN_COUNT-1:0]  pin_drive;
  logic                           lock_active;

  modport source (output valid, read_data, pin_drive, lock_active, input ready);
  modport sink   (input valid, read_data, pin_drive, lock_active, output ready);
endinterface

FILE: rtl/gpl_lock.sv
`timescale 1ns / 1ps
module gpl_lock (
  input  logic                   clk,
  input  logic                   rst,
  input  gpl_pkg::gpl_lock_req_t req,
  output gpl_pkg::gpl_lock_st_t  st
);
  import gpl_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_ZERO = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [PIN_COUNT-1:0] lock_mask, lock_mask_next;
  logic                 lock_key, lock_key_next;
  logic [1:0]           lock_phase, lock_phase_next;
  logic                 one, same;

  assign one  = req.data[KEY_POS];
  assign same = (req.data[PIN_COUNT-1:0] == lock_mask);

  always_comb begin
    lock_mask_next  = lock_mask;
    lock_key_next   = lock_key;
    lock_phase_next = lock_phase;
    if (req.fire && req.sel) begin
      if (req.wr == OP_WRITE) begin
        if (lock_key) begin
          lock_phase_next = PH_IDLE;
        end else begin
          priority if (lock_phase == PH_ONE && !one && same) begin
            lock_phase_next = PH_ZERO;
          end else if (lock_phase == PH_ZERO && one && same) begin
            lock_phase_next = PH_DONE;
          end else begin
            lock_phase_next = one ? PH_ONE : PH_IDLE;
          end
          lock_mask_next = req.data[PIN_COUNT-1:0];
        end
      end else begin
        if (!lock_key && lock_phase == PH_DONE) begin
          lock_key_next = 1'b1;
        end
        lock_phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mask  <= '0;
      lock_key   <= 1'b0;
      lock_phase <= PH_IDLE;
    end else begin
      lock_mask  <= lock_mask_next;
      lock_key   <= lock_key_next;
      lock_phase <= lock_phase_next;
    end
  end

  assign st.mask     = lock_mask;
  assign st.key      = lock_key;
  assign st.key_next = lock_key_next;

endmodule

FILE: rtl/gpio_port_registers_with_lock.sv
`timescale 1ns / 1ps
// The response word is registered: it appears in the cycle after its access word is accepted.
// Throughput: one access word per cycle while rsp.ready takes each word; the response
// register frees itself in the cycle its word is taken, so a new access is accepted alongside.
// Reset (rst, synchronous): config words to 0x44444444, output latch, lock
// bits, lock key and sequence phase to zero, response register empty.
module gpio_port_registers_with_lock (
  input logic      clk,
  input logic      rst,
  gpl_req_if.sink  req,
  gpl_rsp_if.source rsp
);
  import gpl_pkg::*;

  logic                 accept;
  logic                 is_wr;
  logic [DATA_W-1:0]    cfg_lo, cfg_lo_next;
  logic [DATA_W-1:0]    cfg_hi, cfg_hi_next;
  logic [PIN_COUNT-1:0] out_latch, out_latch_next;
  logic [DATA_W-1:0]    rd_next;
  logic [DATA_W-1:0]    keep_lo, keep_hi;
  logic                 rsp_valid;
  logic [DATA_W-1:0]    rsp_data;
  logic [PIN_COUNT-1:0] rsp_drive;
  logic                 rsp_lock;
  gpl_lock_req_t        lk_req;
  gpl_lock_st_t         lk_st;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_wr     = (req.opcode == OP_WRITE);

  assign lk_req.fire = accept;
  assign lk_req.wr   = req.opcode;
  assign lk_req.sel  = (req.reg_index == REG_LOCK);
  assign lk_req.data = req.write_data;

  gpl_lock u_lock (
    .clk (clk),
    .rst (rst),
    .req (lk_req),
    .st  (lk_st)
  );

  always_comb begin
    for (int i = 0; i < HALF_PINS; i++) begin
      keep_lo[i*NIB_W +: NIB_W] = {NIB_W{lk_st.key && lk_st.mask[i]}};
      keep_hi[i*NIB_W +: NIB_W] = {NIB_W{lk_st.key && lk_st.mask[i+HALF_PINS]}};
    end
  end

  always_comb begin
    cfg_lo_next    = cfg_lo;
    cfg_hi_next    = cfg_hi;
    out_latch_next = out_latch;
    rd_next        = '0;
    if (is_wr) begin
      unique case (req.reg_index)
        REG_CFG_LO: cfg_lo_next = (cfg_lo & keep_lo) | (req.write_data & ~keep_lo);
        REG_CFG_HI: cfg_hi_next = (cfg_hi & keep_hi) | (req.write_data & ~keep_hi);
        REG_OUTPUT: out_latch_next = req.write_data[PIN_COUNT-1:0];
        REG_SET:    out_latch_next = out_latch | req.write_data[PIN_COUNT-1:0];
        REG_RESET:  out_latch_next = out_latch & ~req.write_data[PIN_COUNT-1:0];
        default:    out_latch_next = out_latch;
      endcase
    end else begin
      unique case (req.reg_index)
        REG_CFG_LO: rd_next = cfg_lo;
        REG_CFG_HI: rd_next = cfg_hi;
        REG_INPUT:  rd_next = {{(DATA_W-PIN_COUNT){1'b0}}, req.pin_levels};
        REG_OUTPUT: rd_next = {{(DATA_W-PIN_COUNT){1'b0}}, out_latch};
        REG_LOCK:   rd_next = {{(DATA_W-PIN_COUNT-1){1'b0}}, lk_st.key, lk_st.mask};
        default:    rd_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_lo    <= CFG_RESET;
      cfg_hi    <= CFG_RESET;
      out_latch <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cfg_lo    <= cfg_lo_next;
        cfg_hi    <= cfg_hi_next;
        out_latch <= out_latch_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data  <= rd_next;
      rsp_drive <= out_latch_next;
      rsp_lock  <= lk_st.key_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.read_data   = rsp_data;
  assign rsp.pin_drive   = rsp_drive;
  assign rsp.lock_active = rsp_lock;

  a_key_sticky: assert property (@(posedge clk) disable iff (rst)
    lk_st.key |=> lk_st.key)
    else $error("lock key cleared while active");

  a_mask_frozen: assert property (@(posedge clk) disable iff (rst)
    lk_st.key |=> $stable(lk_st.mask))
    else $error("lock bits changed while key active");

  a_key_by_read: assert property (@(posedge clk) disable iff (rst)
    (!lk_st.key && !(accept && lk_req.sel && !is_wr)) |=> !lk_st.key)
    else $error("lock key set without a lock register read");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.valid && rsp.pin_drive == out_latch && rsp.lock_active == lk_st.key))
    else $error("response word missing or out of step with state");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gpl_pkg::*;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_ONE, SEQ_ZERO, SEQ_ARMED} lock_seq_t;

  typedef struct packed {
    logic [DATA_W-1:0]    rd;
    logic [PIN_COUNT-1:0] drive;
    logic                 key;
  } port_resp_t;

  logic clk = 1'b0;
  logic rst;

  gpl_req_if req_ch ();
  gpl_rsp_if rsp_ch ();

  gpio_port_registers_with_lock dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [DATA_W-1:0]    cfg_lo_q;
  logic [DATA_W-1:0]    cfg_hi_q;
  logic [PIN_COUNT-1:0] latch_q;
  logic [PIN_COUNT-1:0] lock_mask_q;
  logic                 lock_key_q;
  lock_seq_t            lock_seq_q;

  port_resp_t port_words_due[$];
  int unsigned words_sent;
  int unsigned fail_count;
  int unsigned hold_left;
  int unsigned rx_stall;
  bit          tx_idle_en;
  bit          rx_idle_en;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] merge_cfg(logic [DATA_W-1:0] old_word,
                                                  logic [DATA_W-1:0] data, int base);
    logic [DATA_W-1:0] keep;
    keep = '0;
    if (lock_key_q) begin
      for (int i = 0; i < HALF_PINS; i++) begin
        if (lock_mask_q[base + i]) keep[NIB_W*i +: NIB_W] = '1;
      end
    end
    return (old_word & keep) | (data & ~keep);
  endfunction

  function automatic port_resp_t predict_access(logic op, logic [IDX_W-1:0] idx,
                                                logic [DATA_W-1:0] data,
                                                logic [PIN_COUNT-1:0] pins);
    port_resp_t r;
    logic [PIN_COUNT-1:0] lck;
    logic one;
    logic same;
    r.rd = '0;
    if (op == OP_WRITE) begin
      case (idx)
        REG_CFG_LO: cfg_lo_q = merge_cfg(cfg_lo_q, data, 0);
        REG_CFG_HI: cfg_hi_q = merge_cfg(cfg_hi_q, data, HALF_PINS);
        REG_OUTPUT: latch_q = data[PIN_COUNT-1:0];
        REG_SET:    latch_q = latch_q | data[PIN_COUNT-1:0];
        REG_RESET:  latch_q = latch_q & ~data[PIN_COUNT-1:0];
        REG_LOCK: begin
          lck  = data[PIN_COUNT-1:0];
          one  = data[KEY_POS];
          same = (lck == lock_mask_q);
          if (lock_key_q) begin
            lock_seq_q = SEQ_IDLE;
          end else begin
            if (lock_seq_q == SEQ_ONE && !one && same) lock_seq_q = SEQ_ZERO;
            else if (lock_seq_q == SEQ_ZERO && one && same) lock_seq_q = SEQ_ARMED;
            else lock_seq_q = one ? SEQ_ONE : SEQ_IDLE;
            lock_mask_q = lck;
          end
        end
        default: ;
      endcase
    end else begin
      case (idx)
        REG_CFG_LO: r.rd = cfg_lo_q;
        REG_CFG_HI: r.rd = cfg_hi_q;
        REG_INPUT:  r.rd = {{(DATA_W-PIN_COUNT){1'b0}}, pins};
        REG_OUTPUT: r.rd = {{(DATA_W-PIN_COUNT){1'b0}}, latch_q};
        REG_LOCK: begin
          r.rd = '0;
          r.rd[PIN_COUNT-1:0] = lock_mask_q;
          r.rd[KEY_POS] = lock_key_q;
          if (!lock_key_q && lock_seq_q == SEQ_ARMED) lock_key_q = 1'b1;
          lock_seq_q = SEQ_IDLE;
        end
        default: ;
      endcase
    end
    r.drive = latch_q;
    r.key   = lock_key_q;
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data,
                           logic [PIN_COUNT-1:0] pins);
    int unsigned gap;
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.reg_index  <= idx;
    req_ch.write_data <= data;
    req_ch.pin_levels <= pins;
    do @(posedge clk); while (!req_ch.ready);
    port_words_due.push_back(predict_access(op, idx, data, pins));
    words_sent++;
    @(negedge clk);
    gap = tx_idle_en ? idle_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_access(bit allow_key);
    logic op;
    logic [IDX_W-1:0] idx;
    op  = 1'($urandom_range(0, 1));
    idx = IDX_W'($urandom_range(0, 7));
    if (!allow_key && op == OP_READ && idx == REG_LOCK && lock_seq_q == SEQ_ARMED)
      op = OP_WRITE;
    send_word(op, idx, rand_data(), PIN_COUNT'($urandom));
  endtask

  task automatic send_lock_word(logic key_bit, logic [PIN_COUNT-1:0] mask);
    logic [DATA_W-1:0] data;
    data = $urandom;
    data[KEY_POS] = key_bit;
    data[PIN_COUNT-1:0] = mask;
    send_word(OP_WRITE, REG_LOCK, data, PIN_COUNT'($urandom));
  endtask

  // write 1, 0, 1, read (or write 0 if key barred); random content, faults
  task automatic send_lock_sequence(bit allow_key);
    logic [PIN_COUNT-1:0] mask;
    int unsigned fault;
    int unsigned at;
    logic key_bit;
    mask  = PIN_COUNT'($urandom);
    fault = $urandom_range(0, 5);
    at    = $urandom_range(1, 3);
    for (int s = 1; s <= 3; s++) begin
      key_bit = (s != 2);
      if (fault == 2 && s == at && s > 1) begin
        send_word(OP_READ, REG_LOCK, $urandom, PIN_COUNT'($urandom));
      end
      if (fault == 0 && s == at) key_bit = !key_bit;
      if (fault == 1 && s == at && s > 1)
        send_lock_word(key_bit, mask ^ (16'h1 << $urandom_range(0, 15)));
      else
        send_lock_word(key_bit, mask);
      if ($urandom_range(0, 3) == 0)
        send_word(OP_WRITE, IDX_W'($urandom_range(0, 5)), $urandom, PIN_COUNT'($urandom));
    end
    if (!allow_key && lock_seq_q == SEQ_ARMED)
      send_lock_word(1'b0, PIN_COUNT'($urandom));
    else
      send_word(OP_READ, REG_LOCK, $urandom, PIN_COUNT'($urandom));
  endtask

  task automatic run_random(int unsigned target, bit allow_key);
    int unsigned mark;
    mark = words_sent;
    while (words_sent < target) begin
      if (words_sent - mark >= 100) begin
        mark = words_sent;
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 3) == 0) send_lock_sequence(allow_key);
      else send_random_access(allow_key);
    end
  endtask

  task automatic test_reset_reads();
    for (int i = 0; i < 8; i++) begin
      send_word(OP_READ, i[IDX_W-1:0], '1, (i % 2) ? 16'hffff : 16'h0000);
    end
  endtask

  task automatic test_register_extremes();
    send_word(OP_WRITE, REG_CFG_LO, 32'hffff_ffff, 16'h0);
    send_word(OP_WRITE, REG_CFG_HI, 32'h0000_0000, 16'hffff);
    send_word(OP_READ,  REG_CFG_LO, 32'h0, 16'h5a5a);
    send_word(OP_READ,  REG_CFG_HI, 32'h0, 16'ha5a5);
    send_word(OP_WRITE, REG_OUTPUT, 32'hffff_ffff, 16'h0);
    send_word(OP_WRITE, REG_RESET,  32'hffff_00ff, 16'h0);
    send_word(OP_WRITE, REG_SET,    32'habcd_0001, 16'h0);
    send_word(OP_WRITE, REG_INPUT,  32'hffff_ffff, 16'hffff);
    send_word(OP_WRITE, REG_NONE,   32'hffff_ffff, 16'hffff);
    send_word(OP_READ,  REG_OUTPUT, 32'hffff_ffff, 16'h0);
  endtask

  task automatic test_lock_deviations();
    send_lock_word(1'b1, 16'hffff);
    send_word(OP_READ, REG_LOCK, 32'h0, 16'h0);
    send_lock_word(1'b1, 16'h1234);
    send_lock_word(1'b0, 16'h1235);
    send_lock_word(1'b1, 16'h1234);
    send_lock_word(1'b1, 16'h1234);
    send_lock_word(1'b0, 16'h1234);
    send_lock_word(1'b1, 16'h1234);
    send_lock_word(1'b1, 16'h1234);
    send_word(OP_READ, REG_LOCK, 32'h0, 16'h0);
    send_lock_word(1'b0, 16'h0000);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_left  = 80;
    for (int i = 0; i < 40; i++) send_random_access(1'b0);
  endtask

  task automatic test_key_sequence();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_word(OP_WRITE, REG_CFG_LO, 32'h1234_5678, 16'h0);
    send_word(OP_WRITE, REG_CFG_HI, 32'h9abc_def0, 16'h0);
    send_lock_word(1'b1, 16'h3ca5);
    send_lock_word(1'b0, 16'h3ca5);
    send_word(OP_WRITE, REG_SET, 32'h0000_0f0f, 16'h0);
    send_lock_word(1'b1, 16'h3ca5);
    send_word(OP_READ, REG_LOCK, 32'h0, 16'h0);
    send_word(OP_READ, REG_LOCK, 32'h0, 16'h0);
    send_lock_word(1'b1, 16'h0000);
    send_lock_word(1'b0, 16'hffff);
    send_word(OP_READ, REG_LOCK, 32'h0, 16'h0);
    send_word(OP_WRITE, REG_CFG_LO, 32'hffff_ffff, 16'h0);
    send_word(OP_READ,  REG_CFG_LO, 32'h0, 16'h0);
    send_word(OP_WRITE, REG_CFG_HI, 32'h0000_0000, 16'h0);
    send_word(OP_READ,  REG_CFG_HI, 32'h0, 16'h0);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rx_idle_en) rx_stall = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    port_resp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (port_words_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: rd=%h drive=%h key=%b",
                   rsp_ch.read_data, rsp_ch.pin_drive, rsp_ch.lock_active);
      end else begin
        want = port_words_due.pop_front();
        if (rsp_ch.read_data !== want.rd || rsp_ch.pin_drive !== want.drive ||
            rsp_ch.lock_active !== want.key) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want rd=%h drive=%h key=%b, got rd=%h drive=%h key=%b",
                     want.rd, want.drive, want.key,
                     rsp_ch.read_data, rsp_ch.pin_drive, rsp_ch.lock_active);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_READ;
    req_ch.reg_index     = REG_CFG_LO;
    req_ch.write_data    = '0;
    req_ch.pin_levels    = '0;
    cfg_lo_q             = CFG_RESET;
    cfg_hi_q             = CFG_RESET;
    latch_q              = '0;
    lock_mask_q          = '0;
    lock_key_q           = 1'b0;
    lock_seq_q           = SEQ_IDLE;
    words_sent           = 0;
    fail_count           = 0;
    hold_left            = 0;
    rx_stall             = 0;
    tx_idle_en           = 1'b0;
    rx_idle_en           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_reads();
    test_register_extremes();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_lock_deviations();
    run_random(440, 1'b0);
    test_backpressure();
    test_key_sequence();
    run_random(850, 1'b1);
    req_ch.valid <= 1'b0;
    while (port_words_due.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
